>>> rtl/rwt_pkg.sv
// Shared types, codes and helpers for the retransmit window tracker.
package rwt_pkg;

    // Input item modes
    localparam logic [1:0] MODE_SEND = 2'd0;
    localparam logic [1:0] MODE_ACK  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // Result event codes
    localparam logic [2:0] EV_ACCEPT  = 3'd0;
    localparam logic [2:0] EV_WINFULL = 3'd1;
    localparam logic [2:0] EV_TABFULL = 3'd2;
    localparam logic [2:0] EV_ACKED   = 3'd3;
    localparam logic [2:0] EV_RESEND  = 3'd4;
    localparam logic [2:0] EV_DROP    = 3'd5;
    localparam logic [2:0] EV_NONE    = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_TRIES   = 2'd1;

    // Reset values and limits
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [2:0]  TRIES_RESET   = 3'd3;
    localparam logic [15:0] WINDOW_RESET  = 16'd7200;
    localparam logic [3:0]  RESULT_LIMIT  = 4'd8;

    typedef struct packed {
        logic [31:0] seq;
        logic [10:0] size;
        logic [2:0]  tries;
        logic [15:0] age;
    } slot_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [31:0] event_seq;
        logic [10:0] event_size;
        logic [15:0] freed_bytes;
        logic [15:0] advertised_window;
        logic [15:0] flight_bytes;
    } res_t;

    function automatic logic [15:0] adv_window(input logic [15:0] limit,
                                               input logic [15:0] flight);
        return (flight >= limit) ? 16'd0 : limit - flight;
    endfunction

    function automatic logic [15:0] flight_sub(input logic [15:0] flight,
                                               input logic [10:0] size);
        return ({5'd0, size} >= flight) ? 16'd0 : flight - {5'd0, size};
    endfunction

    function automatic logic [15:0] add_sat(input logic [15:0] base,
                                            input logic [10:0] size);
        logic [16:0] sum;
        sum = {1'b0, base} + {6'd0, size};
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

endpackage

>>> rtl/retransmit_window_tracker_unit.sv
// Retransmit window tracker: fragment table, ack release and tick-driven timeout scan.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------------
//  command   | start / busy           | mode, seq_number, payload_length,
//            |                        | ack_number, peer_window
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  result    | result_valid (strobe)  | event_res, event_seq, event_size,
//            |                        | freed_bytes, advertised_window,
//            |                        | flight_bytes, last
//
// A send (or an unused mode) is decided in the accept cycle; its single result
// shows in the next cycle and busy never rises, so a new item may follow at once.
// Ack and tick walk the table one slot per cycle through a table memory with one
// write port and a registered read port: busy stays high through the scan and finish
// states, and the results of the walk leave one at a time.
// Reset (rst_n low, asynchronous) empties the table, clears bytes in flight
// and loads the window and both registers with their defaults.
// The receiver cannot stall: every result is taken in the cycle it is shown.
module retransmit_window_tracker_unit #(
    parameter int TABLE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] seq_number,
    input  logic [10:0] payload_length,
    input  logic [31:0] ack_number,
    input  logic [15:0] peer_window,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        result_valid,
    output logic [2:0]  event_res,
    output logic [31:0] event_seq,
    output logic [10:0] event_size,
    output logic [15:0] freed_bytes,
    output logic [15:0] advertised_window,
    output logic [15:0] flight_bytes,
    output logic        last
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Fragment table, compacted in place during each walk
    rwt_pkg::slot_t table_mem [TABLE_DEPTH];
    rwt_pkg::slot_t rdata_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    rwt_pkg::slot_t   mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    state_t         state_reg, state_next;
    logic [1:0]     cmd_reg, cmd_next;
    logic [31:0]    ack_reg, ack_next;
    logic [15:0]    pwin_reg, pwin_next;
    logic [CNT_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] scan_len_reg, scan_len_next;
    logic             proc_valid_reg, proc_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]    bytes_reg, bytes_next;
    logic [15:0]    window_reg, window_next;
    logic [15:0]    timeout_reg, timeout_next;
    logic [2:0]     max_tries_reg, max_tries_next;
    logic [15:0]    freed_reg, freed_next;
    logic [3:0]     nres_reg, nres_next;
    logic           pend_valid_reg, pend_valid_next;
    rwt_pkg::res_t  pend_reg, pend_next;
    rwt_pkg::res_t  out_reg, out_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_last_reg, out_last_next;

    assign busy              = (state_reg != ST_IDLE);
    assign cfg_ready         = 1'b1;
    assign result_valid      = out_valid_reg;
    assign last              = out_last_reg;
    assign event_res         = out_reg.event_res;
    assign event_seq         = out_reg.event_seq;
    assign event_size        = out_reg.event_size;
    assign freed_bytes       = out_reg.freed_bytes;
    assign advertised_window = out_reg.advertised_window;
    assign flight_bytes      = out_reg.flight_bytes;

    // Read the slot under the read pointer every cycle
    assign mem_raddr = rd_ptr_reg[IDX_W-1:0];

    always_comb
    begin
        rwt_pkg::slot_t entry;
        rwt_pkg::res_t  new_res;
        logic           emit;
        logic [15:0]    age_inc;
        logic [16:0]    need;

        state_next      = state_reg;
        cmd_next        = cmd_reg;
        ack_next        = ack_reg;
        pwin_next       = pwin_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        scan_len_next   = scan_len_reg;
        proc_valid_next = 1'b0;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        window_next     = window_reg;
        timeout_next    = timeout_reg;
        max_tries_next  = max_tries_reg;
        freed_next      = freed_reg;
        nres_next       = nres_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        out_valid_next  = 1'b0;
        out_last_next   = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = wr_ptr_reg[IDX_W-1:0];
        mem_wdata       = rdata_reg;
        entry           = rdata_reg;
        new_res         = '0;
        emit            = 1'b0;
        age_inc         = (rdata_reg.age == 16'hFFFF) ? rdata_reg.age : rdata_reg.age + 16'd1;
        need            = {1'b0, bytes_reg} + {6'd0, payload_length};

        // Register writes must arrive only while idle; the block does not enforce this
        if (cfg_valid)
        begin
            case (cfg_index)
                rwt_pkg::CFG_TIMEOUT: timeout_next   = cfg_data;
                rwt_pkg::CFG_TRIES:   max_tries_next = cfg_data[2:0];
                default:              ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        rwt_pkg::MODE_SEND:
                        begin
                            // Window test first, then table space
                            if (need > {1'b0, window_reg})
                            begin
                                out_next = '{rwt_pkg::EV_WINFULL, seq_number, payload_length,
                                             16'd0, rwt_pkg::adv_window(window_reg, bytes_reg),
                                             bytes_reg};
                            end
                            else if (count_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                out_next = '{rwt_pkg::EV_TABFULL, seq_number, payload_length,
                                             16'd0, rwt_pkg::adv_window(window_reg, bytes_reg),
                                             bytes_reg};
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[IDX_W-1:0];
                                mem_wdata  = '{seq_number, payload_length, 3'd1, 16'd0};
                                count_next = count_reg + CNT_W'(1);
                                bytes_next = rwt_pkg::add_sat(bytes_reg, payload_length);
                                out_next   = '{rwt_pkg::EV_ACCEPT, seq_number, payload_length,
                                               16'd0, rwt_pkg::adv_window(window_reg, bytes_next),
                                               bytes_next};
                            end
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                        end
                        rwt_pkg::MODE_ACK, rwt_pkg::MODE_TICK:
                        begin
                            cmd_next        = mode;
                            ack_next        = ack_number;
                            pwin_next       = peer_window;
                            rd_ptr_next     = '0;
                            wr_ptr_next     = '0;
                            scan_len_next   = count_reg;
                            freed_next      = 16'd0;
                            nres_next       = 4'd0;
                            pend_valid_next = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        default:
                        begin
                            out_next       = '{rwt_pkg::EV_NONE, 32'd0, 11'd0, 16'd0,
                                               rwt_pkg::adv_window(window_reg, bytes_reg),
                                               bytes_reg};
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b1;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Issue the next read
                if (rd_ptr_reg < scan_len_reg)
                begin
                    rd_ptr_next     = rd_ptr_reg + CNT_W'(1);
                    proc_valid_next = 1'b1;
                end

                // Process the slot read last cycle; kept slots move down to wr_ptr
                if (proc_valid_reg)
                begin
                    if (cmd_reg == rwt_pkg::MODE_ACK)
                    begin
                        if (entry.seq <= ack_reg)
                        begin
                            freed_next = rwt_pkg::add_sat(freed_reg, entry.size);
                            bytes_next = rwt_pkg::flight_sub(bytes_reg, entry.size);
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = entry;
                            wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (nres_reg < rwt_pkg::RESULT_LIMIT && age_inc >= timeout_reg)
                        begin
                            emit      = 1'b1;
                            nres_next = nres_reg + 4'd1;
                            if (entry.tries >= max_tries_reg)
                            begin
                                bytes_next = rwt_pkg::flight_sub(bytes_reg, entry.size);
                                count_next = count_reg - CNT_W'(1);
                                new_res    = '{rwt_pkg::EV_DROP, entry.seq, entry.size, 16'd0,
                                               rwt_pkg::adv_window(window_reg, bytes_next),
                                               bytes_next};
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                mem_wdata   = '{entry.seq, entry.size, entry.tries + 3'd1, 16'd0};
                                wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                                new_res     = '{rwt_pkg::EV_RESEND, entry.seq, entry.size, 16'd0,
                                                rwt_pkg::adv_window(window_reg, bytes_reg),
                                                bytes_reg};
                            end
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            mem_wdata   = '{entry.seq, entry.size, entry.tries, age_inc};
                            wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                        end
                    end
                end

                // Hold each result back one step so the final one can carry last
                if (emit)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_next       = new_res;
                    pend_valid_next = 1'b1;
                end

                if (!proc_valid_reg && rd_ptr_reg == scan_len_reg)
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (cmd_reg == rwt_pkg::MODE_ACK)
                begin
                    window_next = pwin_reg;
                    out_next    = '{rwt_pkg::EV_ACKED, 32'd0, 11'd0, freed_reg,
                                    rwt_pkg::adv_window(pwin_reg, bytes_reg), bytes_reg};
                end
                else if (pend_valid_reg)
                begin
                    out_next = pend_reg;
                end
                else
                begin
                    out_next = '{rwt_pkg::EV_NONE, 32'd0, 11'd0, 16'd0,
                                 rwt_pkg::adv_window(window_reg, bytes_reg), bytes_reg};
                end
                out_valid_next  = 1'b1;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cmd_reg        <= rwt_pkg::MODE_SEND;
            ack_reg        <= '0;
            pwin_reg       <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            scan_len_reg   <= '0;
            proc_valid_reg <= 1'b0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            window_reg     <= rwt_pkg::WINDOW_RESET;
            timeout_reg    <= rwt_pkg::TIMEOUT_RESET;
            max_tries_reg  <= rwt_pkg::TRIES_RESET;
            freed_reg      <= '0;
            nres_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            ack_reg        <= ack_next;
            pwin_reg       <= pwin_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            scan_len_reg   <= scan_len_next;
            proc_valid_reg <= proc_valid_next;
            count_reg      <= count_next;
            bytes_reg      <= bytes_next;
            window_reg     <= window_next;
            timeout_reg    <= timeout_next;
            max_tries_reg  <= max_tries_next;
            freed_reg      <= freed_next;
            nres_reg       <= nres_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= table_mem[mem_raddr];
    end

    // The table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("slot count above table depth");

    // An empty table has nothing in flight
    a_empty_no_flight: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> bytes_reg == 16'd0)
        else $error("bytes in flight with empty table");

    // A result follows an accepted item or comes out of a walk
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy || start))
        else $error("result without a cause");

    // Compaction never writes ahead of the read pointer
    a_ptr_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> wr_ptr_reg <= rd_ptr_reg)
        else $error("write pointer passed read pointer");

    // A tick handles no more expiries than the result limit
    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= rwt_pkg::RESULT_LIMIT)
        else $error("too many tick results");

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the retransmit window tracker unit.
module tb;

    // Table geometry and run timing
    localparam int DEPTH        = 8;
    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_GAP      = 10;
    // Room after the longest walk and its last result, with margin to spare
    localparam int DRAIN_CYCLES = 16;
    localparam int DRAIN_GUARD  = 20000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 48;

    // Codes the package leaves unnamed
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [2:0]  code;
        logic [31:0] seq;
        logic [10:0] len;
        logic [15:0] freed;
        logic [15:0] adv;
        logic [15:0] flight;
        logic        last;
    } track_event_t;

    // Shadow of the fragment table, plus the queue of results it predicts
    class window_scoreboard;
        logic [31:0]  ent_seq   [DEPTH];
        logic [10:0]  ent_len   [DEPTH];
        logic [2:0]   ent_tries [DEPTH];
        logic [15:0]  ent_age   [DEPTH];
        logic [3:0]   ent_count;
        logic [15:0]  inflight;
        logic [15:0]  peer_limit;
        logic [15:0]  rto_ticks;
        logic [2:0]   try_limit;
        track_event_t pending_events[$];
        int           errors;

        function new();
            ent_count  = 4'd0;
            inflight   = 16'd0;
            peer_limit = rwt_pkg::WINDOW_RESET;
            rto_ticks  = rwt_pkg::TIMEOUT_RESET;
            try_limit  = rwt_pkg::TRIES_RESET;
            errors     = 0;
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [15:0] data);
            if (idx == rwt_pkg::CFG_TIMEOUT)
                rto_ticks = data;
            else if (idx == rwt_pkg::CFG_TRIES)
                try_limit = data[2:0];
        endfunction

        function track_event_t make_event(input logic [2:0] code, input logic [31:0] seq,
                                          input logic [10:0] len, input logic [15:0] freed);
            track_event_t ev;
            ev.code   = code;
            ev.seq    = seq;
            ev.len    = len;
            ev.freed  = freed;
            ev.adv    = (inflight >= peer_limit) ? 16'd0 : peer_limit - inflight;
            ev.flight = inflight;
            ev.last   = 1'b0;
            return ev;
        endfunction

        function void release_bytes(input logic [10:0] len);
            if ({5'd0, len} >= inflight)
                inflight = 16'd0;
            else
                inflight = inflight - {5'd0, len};
        endfunction

        function void remove_entry(input int k);
            for (int j = k; j + 1 < ent_count; j++) begin
                ent_seq[j]   = ent_seq[j + 1];
                ent_len[j]   = ent_len[j + 1];
                ent_tries[j] = ent_tries[j + 1];
                ent_age[j]   = ent_age[j + 1];
            end
            ent_count = ent_count - 4'd1;
        endfunction

        function void note_command(input logic [1:0] m, input logic [31:0] seq,
                                   input logic [10:0] len, input logic [31:0] ack,
                                   input logic [15:0] pwin);
            track_event_t batch[$];
            track_event_t ev;
            logic [31:0]  total;
            logic [31:0]  freed_sum;
            logic [31:0]  s;
            logic [10:0]  z;
            int           k;
            case (m)
                rwt_pkg::MODE_SEND: begin
                    total = {16'd0, inflight} + {21'd0, len};
                    if (total > {16'd0, peer_limit})
                        batch.push_back(make_event(rwt_pkg::EV_WINFULL, seq, len, 16'd0));
                    else if (ent_count >= DEPTH)
                        batch.push_back(make_event(rwt_pkg::EV_TABFULL, seq, len, 16'd0));
                    else begin
                        ent_seq[ent_count]   = seq;
                        ent_len[ent_count]   = len;
                        ent_tries[ent_count] = 3'd1;
                        ent_age[ent_count]   = 16'd0;
                        ent_count = ent_count + 4'd1;
                        inflight  = (total > 32'hFFFF) ? 16'hFFFF : total[15:0];
                        batch.push_back(make_event(rwt_pkg::EV_ACCEPT, seq, len, 16'd0));
                    end
                end
                rwt_pkg::MODE_ACK: begin
                    freed_sum = 32'd0;
                    k = 0;
                    while (k < ent_count) begin
                        if (ent_seq[k] <= ack) begin
                            freed_sum = freed_sum + {21'd0, ent_len[k]};
                            release_bytes(ent_len[k]);
                            remove_entry(k);
                        end else
                            k++;
                    end
                    if (freed_sum > 32'hFFFF)
                        freed_sum = 32'hFFFF;
                    peer_limit = pwin;
                    batch.push_back(make_event(rwt_pkg::EV_ACKED, 32'd0, 11'd0,
                                               freed_sum[15:0]));
                end
                rwt_pkg::MODE_TICK: begin
                    k = 0;
                    while (k < ent_count) begin
                        if (ent_age[k] != 16'hFFFF)
                            ent_age[k] = ent_age[k] + 16'd1;
                        if (batch.size() < rwt_pkg::RESULT_LIMIT && ent_age[k] >= rto_ticks) begin
                            if (ent_tries[k] >= try_limit) begin
                                // Drop: the next entry shifts into slot k and is aged next
                                s = ent_seq[k];
                                z = ent_len[k];
                                release_bytes(z);
                                remove_entry(k);
                                batch.push_back(make_event(rwt_pkg::EV_DROP, s, z, 16'd0));
                            end else begin
                                ent_tries[k] = ent_tries[k] + 3'd1;
                                ent_age[k]   = 16'd0;
                                batch.push_back(make_event(rwt_pkg::EV_RESEND, ent_seq[k],
                                                           ent_len[k], 16'd0));
                                k++;
                            end
                        end else
                            k++;
                    end
                    if (batch.size() == 0)
                        batch.push_back(make_event(rwt_pkg::EV_NONE, 32'd0, 11'd0, 16'd0));
                end
                default: batch.push_back(make_event(rwt_pkg::EV_NONE, 32'd0, 11'd0, 16'd0));
            endcase
            ev = batch.pop_back();
            ev.last = 1'b1;
            batch.push_back(ev);
            foreach (batch[i])
                pending_events.push_back(batch[i]);
        endfunction

        function void field_check(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_event(input track_event_t got);
            track_event_t want;
            if (pending_events.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual event_res %0d seq %0h",
                         $time, got.code, got.seq);
                return;
            end
            want = pending_events.pop_front();
            field_check("event_res", 32'(want.code), 32'(got.code));
            field_check("event_seq", want.seq, got.seq);
            field_check("event_size", 32'(want.len), 32'(got.len));
            field_check("freed_bytes", 32'(want.freed), 32'(got.freed));
            field_check("advertised_window", 32'(want.adv), 32'(got.adv));
            field_check("flight_bytes", 32'(want.flight), 32'(got.flight));
            field_check("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [31:0] seq_number;
    logic [10:0] payload_length;
    logic [31:0] ack_number;
    logic [15:0] peer_window;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        result_valid;
    logic [2:0]  event_res;
    logic [31:0] event_seq;
    logic [10:0] event_size;
    logic [15:0] freed_bytes;
    logic [15:0] advertised_window;
    logic [15:0] flight_bytes;
    logic        last;

    window_scoreboard sb;
    track_event_t     seen_event;
    logic [31:0]      next_seq;
    bit               no_idle;

    retransmit_window_tracker_unit #(
        .TABLE_DEPTH (DEPTH)
    ) DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .mode              (mode),
        .seq_number        (seq_number),
        .payload_length    (payload_length),
        .ack_number        (ack_number),
        .peer_window       (peer_window),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .result_valid      (result_valid),
        .event_res         (event_res),
        .event_seq         (event_seq),
        .event_size        (event_size),
        .freed_bytes       (freed_bytes),
        .advertised_window (advertised_window),
        .flight_bytes      (flight_bytes),
        .last              (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Sample each result at the edge that ends its strobe cycle; the strobe
    // lasts one cycle only, so check it right here.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            seen_event.code   = event_res;
            seen_event.seq    = event_seq;
            seen_event.len    = event_size;
            seen_event.freed  = freed_bytes;
            seen_event.adv    = advertised_window;
            seen_event.flight = flight_bytes;
            seen_event.last   = last;
            sb.check_event(seen_event);
        end
    end

    // Issue one item. Enter and leave just after a falling edge; start is
    // left high so a back-to-back item follows without a dead cycle.
    task automatic issue_command(input logic [1:0] m, input logic [31:0] seq,
                                 input logic [10:0] len, input logic [31:0] ack,
                                 input logic [15:0] pwin);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            // Hold start low for the drawn gap
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start          = 1'b1;
        mode           = m;
        seq_number     = seq;
        payload_length = len;
        ack_number     = ack;
        peer_window    = pwin;
        // Keep the item on the port until an edge sees busy low
        do
            @(posedge clk);
        while (busy);
        sb.note_command(m, seq, len, ack, pwin);
        @(negedge clk);
    endtask

    // Drop start, wait out every expected result, then let the walk finish
    task automatic drain_results();
        int guard;
        start = 1'b0;
        guard = 0;
        while (sb.outstanding() != 0 && guard < DRAIN_GUARD)
        begin
            @(negedge clk);
            guard++;
        end
        while (busy && guard < DRAIN_GUARD)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        repeat ($urandom_range(0, 3)) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Load both registers while the block is idle; junk above the tries
    // field and writes to unused indexes must be ignored.
    task automatic configure(input logic [15:0] timeout_val, input logic [2:0] tries_val);
        logic [15:0] tries_word;
        drain_results();
        tries_word = 16'($urandom);
        tries_word[2:0] = tries_val;
        write_register(rwt_pkg::CFG_TIMEOUT, timeout_val);
        write_register(rwt_pkg::CFG_TRIES, tries_word);
        if ($urandom_range(0, 1) == 1)
            write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
    endtask

    // Random traffic: mostly a sender with rising sequence numbers and acks
    // that land inside the outstanding range, with noise mixed in.
    task automatic run_phase(input int count);
        int          i;
        int          pick;
        int          r;
        logic [1:0]  m;
        logic [31:0] s;
        logic [31:0] a;
        logic [10:0] len;
        logic [15:0] w;
        for (i = 0; i < count; i++)
        begin
            // Fill unused fields with noise
            s    = $urandom;
            a    = $urandom;
            len  = 11'($urandom_range(0, 1440));
            w    = 16'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                m = rwt_pkg::MODE_SEND;
                r = $urandom_range(0, 9);
                if (r != 0)
                begin
                    s = next_seq;
                    next_seq = next_seq + $urandom_range(1, 1440);
                end
                r = $urandom_range(0, 9);
                if (r == 0)
                    len = 11'd0;
                else if (r == 1)
                    len = 11'd1440;
            end
            else if (pick < 60)
            begin
                m = rwt_pkg::MODE_ACK;
                r = $urandom_range(0, 19);
                if (r == 0)
                    a = 32'hFFFF_FFFF;
                else if (r == 1)
                    a = 32'd0;
                else if (r > 4)
                    a = next_seq - $urandom_range(0, 12000);
                r = $urandom_range(0, 99);
                if (r < 60)
                    w = 16'($urandom_range(6000, 65535));
                else if (r < 75)
                    w = 16'hFFFF;
                else if (r < 90)
                    w = 16'($urandom_range(0, 6000));
                else
                    w = 16'd0;
            end
            else if (pick < 95)
                m = rwt_pkg::MODE_TICK;
            else
                m = MODE_SPARE;
            issue_command(m, s, len, a, w);
        end
    endtask

    initial
    begin
        int          p;
        logic [15:0] timeout_val;
        logic [2:0]  tries_val;

        sb             = new();
        rst_n          = 1'b0;
        start          = 1'b0;
        mode           = rwt_pkg::MODE_SEND;
        seq_number     = 32'd0;
        payload_length = 11'd0;
        ack_number     = 32'd0;
        peer_window    = 16'd0;
        cfg_valid      = 1'b0;
        cfg_index      = rwt_pkg::CFG_TIMEOUT;
        cfg_data       = 16'd0;
        no_idle        = 1'b0;
        next_seq       = $urandom;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset register values.
        // Tick on an empty table, then the unused mode: one idle result each.
        issue_command(rwt_pkg::MODE_TICK, 32'd0, 11'd0, 32'd0, 16'd0);
        issue_command(MODE_SPARE, 32'hFFFF_FFFF, 11'd1440, 32'hFFFF_FFFF, 16'hFFFF);
        // Extreme fields, then fill the reset window exactly
        issue_command(rwt_pkg::MODE_SEND, 32'd0, 11'd0, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_SEND, 32'hFFFF_FFFF, 11'd1440, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_SEND, 32'd100, 11'd1440, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_SEND, 32'd200, 11'd1440, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_SEND, 32'd300, 11'd1440, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_SEND, 32'd400, 11'd1440, 32'd0, 16'd0);
        // Window is exactly full: one more byte is refused
        issue_command(rwt_pkg::MODE_SEND, 32'd500, 11'd1, 32'd0, 16'd0);
        // Ack of a zero-length fragment frees nothing; open the window wide
        issue_command(rwt_pkg::MODE_ACK, 32'd0, 11'd0, 32'd0, 16'hFFFF);
        issue_command(rwt_pkg::MODE_SEND, 32'd600, 11'd1000, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_SEND, 32'd700, 11'd1000, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_SEND, 32'd800, 11'd1000, 32'd0, 16'd0);
        // Table full with room in the window
        issue_command(rwt_pkg::MODE_SEND, 32'd900, 11'd1440, 32'd0, 16'd0);
        // Close the window with the table full: the window test wins
        issue_command(rwt_pkg::MODE_ACK, 32'd0, 11'd0, 32'd50, 16'd0);
        issue_command(rwt_pkg::MODE_SEND, 32'd1000, 11'd0, 32'd0, 16'd0);
        // Nothing has aged to the default timeout yet
        issue_command(rwt_pkg::MODE_TICK, 32'd0, 11'd0, 32'd0, 16'd0);

        // Short timeout: a full table resends all eight, then drops all eight
        configure(16'd1, 3'd2);
        issue_command(rwt_pkg::MODE_TICK, 32'd0, 11'd0, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_TICK, 32'd0, 11'd0, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_ACK, 32'd0, 11'd0, 32'hFFFF_FFFF, rwt_pkg::WINDOW_RESET);

        // Zero timeout and zero tries: every tick drops every entry
        configure(16'd0, 3'd0);
        issue_command(rwt_pkg::MODE_SEND, 32'd5, 11'd17, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_TICK, 32'd0, 11'd0, 32'd0, 16'd0);
        issue_command(rwt_pkg::MODE_TICK, 32'd0, 11'd0, 32'd0, 16'd0);

        // Random phases across several settings, extremes first
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       begin timeout_val = 16'd1;     tries_val = 3'd1; end
                1:       begin timeout_val = 16'hFFFF;  tries_val = 3'd7; end
                2:       begin timeout_val = 16'd3;     tries_val = 3'd7; end
                3:       begin timeout_val = 16'd2;     tries_val = 3'd3; end
                4:       begin timeout_val = 16'd0;     tries_val = 3'd0; end
                5:       begin
                    timeout_val = rwt_pkg::TIMEOUT_RESET;
                    tries_val   = rwt_pkg::TRIES_RESET;
                end
                default: begin
                    timeout_val = 16'($urandom_range(1, 6));
                    tries_val   = 3'($urandom_range(1, 7));
                end
            endcase
            configure(timeout_val, tries_val);
            // Every third phase runs back to back with no idle cycles
            no_idle = (p % 3 == 1);
            run_phase(PHASE_ITEMS);
            no_idle = 1'b0;
        end

        // Wait out the tail and report
        drain_results();
        if (sb.outstanding() != 0)
            $display("%0t ns: %0d expected results never arrived", $time, sb.outstanding());
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hard limit on the run, far beyond the slowest correct run
    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> sim.f
rtl/rwt_pkg.sv
rtl/retransmit_window_tracker_unit.sv
sim/tb.sv
